[design/favorite_bitmap_select_core_macros.svh]
`ifndef FAVORITE_BITMAP_SELECT_CORE_MACROS_SVH
`define FAVORITE_BITMAP_SELECT_CORE_MACROS_SVH

// Property holds on every clock edge out of reset.
`define FBS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent holds on the edge after the antecedent.
`define FBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fbs_pkg.sv]
`timescale 1ns / 1ps

package fbs_pkg;

  localparam int MaxIds    = 32768;
  localparam int WordBits  = 32;
  localparam int WordCount = (MaxIds + WordBits - 1) / WordBits;
  localparam int AddrW     = $clog2(WordCount);
  localparam int BitW      = $clog2(WordBits);
  localparam int IdW       = 15;
  localparam int LimitW    = 16;
  localparam int CntW      = $clog2(MaxIds + 1);
  localparam int ModeW     = 2;

  localparam logic [ModeW-1:0] ModeSet    = 2'd0;
  localparam logic [ModeW-1:0] ModeClear  = 2'd1;
  localparam logic [ModeW-1:0] ModeTest   = 2'd2;
  localparam logic [ModeW-1:0] ModeSelect = 2'd3;

  typedef struct packed {
    logic            in_range;
    logic            is_marked;
    logic            found;
    logic [IdW-1:0]  position;
    logic [CntW-1:0] marked_count;
  } rsp_t;

endpackage

[design/fbs_if.sv]
`timescale 1ns / 1ps

interface fbs_req_if;
  logic                      valid;
  logic                      ready;
  logic [fbs_pkg::ModeW-1:0] mode;
  logic [fbs_pkg::IdW-1:0]   item_id;
  logic [fbs_pkg::IdW-1:0]   rank;

  modport source (output valid, mode, item_id, rank, input ready);
  modport sink   (input valid, mode, item_id, rank, output ready);
endinterface

interface fbs_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     in_range;
  logic                     is_marked;
  logic                     found;
  logic [fbs_pkg::IdW-1:0]  position;
  logic [fbs_pkg::CntW-1:0] marked_count;

  modport source (output valid, in_range, is_marked, found, position, marked_count,
                  input ready);
  modport sink   (input valid, in_range, is_marked, found, position, marked_count,
                  output ready);
endinterface

[design/fbs_engine.sv]
`timescale 1ns / 1ps
`include "favorite_bitmap_select_core_macros.svh"

module fbs_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fbs_pkg::LimitW-1:0]   id_limit_i,
  fbs_req_if.sink                      req_i,
  output logic                         res_valid_o,
  output fbs_pkg::rsp_t                res_o,
  input  logic                         res_ready_i
);

  localparam int AddrW    = fbs_pkg::AddrW;
  localparam int BitW     = fbs_pkg::BitW;
  localparam int IdW      = fbs_pkg::IdW;
  localparam int CntW     = fbs_pkg::CntW;
  localparam int WordBits = fbs_pkg::WordBits;
  localparam int CmpW     = fbs_pkg::LimitW + 1;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(fbs_pkg::WordCount - 1);
  localparam logic [CmpW-1:0]  MaxLimit = CmpW'(fbs_pkg::MaxIds);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRmw   = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StBits  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  function automatic logic [BitW:0] popcount(input logic [WordBits-1:0] w);
    logic [BitW:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      n = n + (BitW+1)'(w[i]);
    end
    return n;
  endfunction

  logic [WordBits-1:0] mem_q [fbs_pkg::WordCount];
  logic [WordBits-1:0] mem_rdata_q;
  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_waddr, mem_raddr;
  logic [WordBits-1:0] mem_wdata;

  logic [2:0]                    state_q, state_d;
  logic [AddrW-1:0]              addr_q, addr_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [fbs_pkg::ModeW-1:0]     mode_q, mode_d;
  logic [IdW-1:0]                id_q, id_d;
  logic [IdW-1:0]                left_q, left_d;
  logic [WordBits-1:0]           word_q, word_d;
  logic [BitW-1:0]               bit_q, bit_d;
  fbs_pkg::rsp_t                 res_q, res_d;

  logic [CmpW-1:0]     eff_limit;
  logic                accept, id_ok, cur;
  logic [BitW:0]       pc;
  logic [WordBits-1:0] bit_mask;

  assign eff_limit = ({1'b0, id_limit_i} > MaxLimit) ? MaxLimit : {1'b0, id_limit_i};
  assign accept    = req_i.valid && req_i.ready;
  assign id_ok     = CmpW'(req_i.item_id) < eff_limit;
  assign cur       = mem_rdata_q[id_q[BitW-1:0]];
  assign bit_mask  = WordBits'(1) << id_q[BitW-1:0];
  assign pc        = popcount(mem_rdata_q);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    mode_d    = mode_q;
    id_d      = id_q;
    left_d    = left_q;
    word_d    = word_q;
    bit_d     = bit_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          mode_d = req_i.mode;
          id_d   = req_i.item_id;
          left_d = req_i.rank;
          if (req_i.mode == fbs_pkg::ModeSelect) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            addr_d    = '0;
            state_d   = StScan;
          end else if (id_ok) begin
            mem_re    = 1'b1;
            mem_raddr = AddrW'(req_i.item_id >> BitW);
            state_d   = StRmw;
          end else begin
            res_d   = '{in_range: 1'b0, is_marked: 1'b0, found: 1'b0,
                        position: '0, marked_count: cnt_q};
            state_d = StDone;
          end
        end
      end
      StRmw: begin
        mem_waddr = AddrW'(id_q >> BitW);
        res_d     = '{in_range: 1'b1, is_marked: cur, found: 1'b0,
                      position: '0, marked_count: cnt_q};
        if (mode_q == fbs_pkg::ModeSet && !cur) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_q | bit_mask;
          cnt_d     = cnt_q + 1'b1;
          res_d.is_marked    = 1'b1;
          res_d.marked_count = cnt_q + 1'b1;
        end else if (mode_q == fbs_pkg::ModeClear && cur) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_q & ~bit_mask;
          cnt_d     = cnt_q - 1'b1;
          res_d.is_marked    = 1'b0;
          res_d.marked_count = cnt_q - 1'b1;
        end
        state_d = StDone;
      end
      StScan: begin
        if (left_q < IdW'(pc)) begin
          word_d  = mem_rdata_q;
          bit_d   = '0;
          state_d = StBits;
        end else begin
          left_d = left_q - IdW'(pc);
          if (addr_q == LastAddr) begin
            res_d   = '{in_range: 1'b1, is_marked: 1'b0, found: 1'b0,
                        position: '0, marked_count: cnt_q};
            state_d = StDone;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = addr_q + 1'b1;
            addr_d    = addr_q + 1'b1;
          end
        end
      end
      StBits: begin
        word_d = word_q >> 1;
        bit_d  = bit_q + 1'b1;
        if (word_q[0]) begin
          if (left_q == '0) begin
            res_d   = '{in_range: 1'b1, is_marked: 1'b0, found: 1'b1,
                        position: IdW'({addr_q, bit_q}), marked_count: cnt_q};
            state_d = StDone;
          end else begin
            left_d = left_q - 1'b1;
          end
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClear;
        addr_d  = '0;
      end
    endcase
    if (cfg_we_i) begin
      state_d = StClear;
      addr_d  = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      addr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    id_q   <= id_d;
    left_q <= left_d;
    word_q <= word_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

  `FBS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(fbs_pkg::MaxIds), "mark count above capacity")
  `FBS_ASSERT_NEXT(a_cfg_clear, cfg_we_i, state_q == StClear && addr_q == '0 && cnt_q == '0, "limit write did not restart clear")
  `FBS_ASSERT_NEXT(a_rmw_cnt, state_q == StRmw && mem_we && !cfg_we_i, cnt_q != $past(cnt_q), "bitmap write without count change")
  `FBS_ASSERT_ALWAYS(a_found_fields, !(state_q == StDone && res_q.found) || (res_q.in_range && !res_q.is_marked), "select result fields inconsistent")

endmodule

[design/fbs_out_stage.sv]
`timescale 1ns / 1ps

module fbs_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  fbs_pkg::rsp_t res_i,
  output logic          res_ready_o,
  fbs_rsp_if.source     rsp_o
);

  logic          valid_q;
  fbs_pkg::rsp_t data_q;
  logic          load;

  assign res_ready_o = !valid_q || rsp_o.ready;
  assign load        = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.in_range     = data_q.in_range;
  assign rsp_o.is_marked    = data_q.is_marked;
  assign rsp_o.found        = data_q.found;
  assign rsp_o.position     = data_q.position;
  assign rsp_o.marked_count = data_q.marked_count;

endmodule

[design/favorite_bitmap_select_core.sv]
// Set/clear/test go through a read-modify-write state, the done state and the output
// register; out-of-range ids go straight to the done state. Select reads one bitmap word
// per cycle from the mark RAM, up to all 1024 words, then walks the hit word bit by bit.
// Throughput: one transaction at a time; a finished result waits in the output register.
// Reset: limit 0, count 0; a clearing pass zeroes all 1024 RAM words with ready low.
// Each limit write restarts the same clearing pass.
`timescale 1ns / 1ps

module favorite_bitmap_select_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fbs_pkg::LimitW-1:0] cfg_wdata_i,
  fbs_req_if.sink                    req_i,
  fbs_rsp_if.source                  rsp_o
);

  logic [fbs_pkg::LimitW-1:0] id_limit_q;
  logic                       res_valid, res_ready;
  fbs_pkg::rsp_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_limit_q <= '0;
    end else if (cfg_we_i) begin
      id_limit_q <= cfg_wdata_i;
    end
  end

  fbs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .id_limit_i  (id_limit_q),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  fbs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .rsp_o       (rsp_o)
  );

endmodule

[dv/tb_favorite_bitmap_select_core.sv]
`timescale 1ns / 1ps

module tb_favorite_bitmap_select_core;
  import fbs_pkg::*;

  typedef enum logic {RowItem, RowLimit} row_kind_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdW-1:0]   item_id;
    logic [IdW-1:0]   rank;
    logic             lit;
    rsp_t             want;
  } mark_op_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [LimitW-1:0] limit;
    mark_op_t          op;
  } dir_row_t;

  localparam rsp_t ZeroRsp    = '0;
  localparam rsp_t SelMissRsp = {1'b1, 1'b0, 1'b0, 15'd0, 16'd0};
  localparam int   NumDirRows = 28;
  localparam int   NumPhases  = 7;
  localparam int   PhaseOps   = 40;
  localparam int   PhaseLimit [NumPhases] = '{32768, 100, 1, 65535, 20000, 40, 32767};

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;

  fbs_req_if req ();
  fbs_rsp_if rsp ();

  favorite_bitmap_select_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req.sink),
    .rsp_o       (rsp.source)
  );

  // shadow state
  logic [WordBits-1:0] mark_words [WordCount];
  logic [CntW-1:0]     marked_total;
  logic [LimitW-1:0]   limit_reg;

  mark_op_t op_queue [$];
  rsp_t     expected_rsps [$];

  int  src_idle_pct;
  int  snk_idle_pct;
  bit  hold_kick;
  int  hot_base;
  int  n_err;
  int  n_ops;
  int  n_sel;
  int  n_hit;
  int  n_oor;
  int  n_limits;

  // set/clear/test marks, select by rank and limit writes
  dir_row_t dir_rows [NumDirRows] = '{
    '{RowItem,  16'd0,     '{ModeTest,   15'd0,     15'd0,     1'b1, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd0,     1'b1, SelMissRsp}},
    '{RowLimit, 16'hffff,  '{ModeTest,   15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'h7fff,  1'b1, SelMissRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'h7fff,  15'h7fff,  1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'h7fff,  15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeTest,   15'h7fff,  15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd1,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd2,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeClear,  15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeClear,  15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowLimit, 16'd5,     '{ModeTest,   15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'd5,     15'd0,     1'b1, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeTest,   15'd4,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'd4,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'd1,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd1,     1'b0, ZeroRsp}},
    '{RowLimit, 16'd32768, '{ModeTest,   15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'd31,    15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'd32,    15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd1,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeClear,  15'd31,    15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowLimit, 16'd0,     '{ModeTest,   15'd0,     15'd0,     1'b0, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSet,    15'd0,     15'd0,     1'b1, ZeroRsp}},
    '{RowItem,  16'd0,     '{ModeSelect, 15'd0,     15'd0,     1'b1, SelMissRsp}}
  };

  function automatic int eff_limit();
    return (int'(limit_reg) > MaxIds) ? MaxIds : int'(limit_reg);
  endfunction

  function automatic rsp_t apply_mark_op(logic [ModeW-1:0] m, logic [IdW-1:0] id,
                                         logic [IdW-1:0] rank);
    rsp_t r;
    int   left;
    int   pc;
    int   idx;
    r    = '0;
    idx  = int'(id);
    if (m == ModeSelect) begin
      r.in_range = 1'b1;
      left       = int'(rank);
      for (int w = 0; w < WordCount && !r.found; w++) begin
        pc = $countones(mark_words[w]);
        if (left >= pc) begin
          left -= pc;
        end else begin
          for (int b = 0; b < WordBits; b++) begin
            if (!r.found && mark_words[w][b]) begin
              if (left == 0) begin
                r.found    = 1'b1;
                r.position = IdW'(w * WordBits + b);
              end else begin
                left--;
              end
            end
          end
        end
      end
    end else if (idx < eff_limit()) begin
      r.in_range = 1'b1;
      if (m == ModeSet && !mark_words[idx / WordBits][idx % WordBits]) begin
        mark_words[idx / WordBits][idx % WordBits] = 1'b1;
        marked_total++;
      end else if (m == ModeClear && mark_words[idx / WordBits][idx % WordBits]) begin
        mark_words[idx / WordBits][idx % WordBits] = 1'b0;
        marked_total--;
      end
      r.is_marked = mark_words[idx / WordBits][idx % WordBits];
    end
    r.marked_count = marked_total;
    return r;
  endfunction

  // mostly in-range ids, half of them clustered so set/clear/test hit the same marks
  function automatic mark_op_t rand_op();
    mark_op_t op;
    int       r;
    int       eff;
    op  = '0;
    eff = eff_limit();
    r   = $urandom_range(99);
    if (r < 35)      op.mode = ModeSet;
    else if (r < 55) op.mode = ModeClear;
    else if (r < 75) op.mode = ModeTest;
    else             op.mode = ModeSelect;
    r = $urandom_range(99);
    if (r < 10 && eff < MaxIds) op.item_id = IdW'($urandom_range(MaxIds - 1, eff));
    else if (r < 55)            op.item_id = IdW'((hot_base + $urandom_range(31)) % eff);
    else if (r < 60)            op.item_id = IdW'(eff - 1);
    else                        op.item_id = IdW'($urandom_range(eff - 1));
    r = $urandom_range(99);
    if (r < 70)      op.rank = IdW'($urandom_range(int'(marked_total)));
    else if (r < 90) op.rank = IdW'($urandom_range(3));
    else             op.rank = IdW'($urandom);
    return op;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (op_queue.size() != 0 || req.valid || expected_rsps.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
    foreach (mark_words[i]) mark_words[i] = '0;
    marked_total = '0;
    n_limits++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : req_driver
    mark_op_t cur;
    rsp_t     pred;
    cur = '0;
    forever begin
      @(posedge clk);
      if (rst_n && (!req.valid || req.ready)) begin
        if (req.valid) begin
          pred = apply_mark_op(cur.mode, cur.item_id, cur.rank);
          n_ops++;
          if (cur.mode == ModeSelect) begin
            n_sel++;
            if (pred.found) n_hit++;
          end else if (!pred.in_range) begin
            n_oor++;
          end
          expected_rsps.push_back(cur.lit ? cur.want : pred);
        end
        if (op_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur = op_queue.pop_front();
          req.valid   <= 1'b1;
          req.mode    <= cur.mode;
          req.item_id <= cur.item_id;
          req.rank    <= cur.rank;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  initial begin : rsp_receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_kick) begin
        hold_kick = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t got;
    rsp_t want;
    if (rst_n && rsp.valid && rsp.ready) begin
      got = {rsp.in_range, rsp.is_marked, rsp.found, rsp.position, rsp.marked_count};
      if (expected_rsps.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("%0t: unexpected transaction in_range=%0b found=%0b count=%0d",
                   $time, got.in_range, got.found, got.marked_count);
      end else begin
        want = expected_rsps.pop_front();
        if (got.in_range != want.in_range || got.is_marked != want.is_marked ||
            got.found != want.found || got.position != want.position ||
            got.marked_count != want.marked_count) begin
          n_err++;
          if (n_err <= 10) begin
            $display("%0t: mismatch exp in_range=%0b marked=%0b found=%0b pos=%0d count=%0d",
                     $time, want.in_range, want.is_marked, want.found, want.position,
                     want.marked_count);
            $display("%0t:          got in_range=%0b marked=%0b found=%0b pos=%0d count=%0d",
                     $time, got.in_range, got.is_marked, got.found, got.position,
                     got.marked_count);
          end
        end
      end
    end
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req.valid    = 1'b0;
    req.mode     = ModeSet;
    req.item_id  = '0;
    req.rank     = '0;
    rsp.ready    = 1'b0;
    hold_kick    = 1'b0;
    hot_base     = 0;
    n_err        = 0;
    n_ops        = 0;
    n_sel        = 0;
    n_hit        = 0;
    n_oor        = 0;
    n_limits     = 0;
    limit_reg    = '0;
    marked_total = '0;
    foreach (mark_words[i]) mark_words[i] = '0;
    src_idle_pct = 22;
    snk_idle_pct = 46;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDirRows; i++) begin
      if (dir_rows[i].kind == RowLimit) begin
        wait_idle();
        write_limit(dir_rows[i].limit);
      end else begin
        op_queue.push_back(dir_rows[i].op);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      if (p < 3) begin
        src_idle_pct = 22;
        snk_idle_pct = 46;
      end else if (p < 5) begin
        src_idle_pct = 46;
        snk_idle_pct = 22;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_limit(LimitW'(PhaseLimit[p]));
      hot_base = $urandom_range(eff_limit() - 1);
      for (int h = 0; h < 2; h++) begin
        for (int k = 0; k < PhaseOps; k++) op_queue.push_back(rand_op());
        // long output stall while requests keep coming
        if (p == 1 && h == 0) begin
          while (op_queue.size() > PhaseOps - 5) @(posedge clk);
          hold_kick = 1'b1;
        end
        wait_idle();
      end
    end

    wait_idle();
    repeat (64) @(posedge clk);
    $display("covered %0d transactions over %0d limit writes: %0d selects (%0d hits),",
             n_ops, n_limits, n_sel, n_hit);
    $display("%0d ids out of range, with a long output stall and full drains", n_oor);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_err);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
